[hdl/sbpd_pkg.sv]
// Shared types and constants for the servo bus packet deframer.
// Depends on nothing; the parser, result register, top level and testbench import it.
`default_nettype none

package sbpd_pkg;

    localparam logic [7:0] MARKER  = 8'hFF;
    localparam logic [7:0] MIN_LEN = 8'd2;

    // One result transfer as it leaves the parser.
    typedef struct packed {
        logic [7:0] packet_id;
        logic [7:0] instruction;
        logic [7:0] payload_count;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       last;
        logic       length_error;
    } result_t;

endpackage

`default_nettype wire

[hdl/sbpd_parser.sv]
// Packet parse state machine: hunts for the marker, takes the header and body.
// Depends on sbpd_pkg for the marker constants and the result type.
`default_nettype none

module sbpd_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output sbpd_pkg::result_t res
);
    import sbpd_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    localparam logic [1:0] HDR_MARK = 2'd0;
    localparam logic [1:0] HDR_ID   = 2'd1;
    localparam logic [1:0] HDR_LEN  = 2'd2;

    phase_t     phase_reg, phase_next;
    logic [1:0] hdr_count_reg, hdr_count_next;
    logic       second_ok_reg, second_ok_next;
    logic [7:0] id_reg, id_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] instr_reg, instr_next;
    logic [7:0] body_count_reg, body_count_next;
    logic [7:0] pcount;
    logic       body_done;

    assign pcount    = length_reg - MIN_LEN;
    // The checksum is the byte at which body_count + 1 reaches the length.
    assign body_done = ({1'b0, body_count_reg} + 9'd1) >= {1'b0, length_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_count_next  = hdr_count_reg;
        second_ok_next  = second_ok_reg;
        id_next         = id_reg;
        length_next     = length_reg;
        instr_next      = instr_reg;
        body_count_next = body_count_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.packet_id   = id_reg;

        if (fire)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    case (hdr_count_reg)
                        HDR_MARK:
                        begin
                            second_ok_next = (rx_byte == MARKER);
                            hdr_count_next = HDR_ID;
                        end
                        HDR_ID:
                        begin
                            id_next        = rx_byte;
                            hdr_count_next = HDR_LEN;
                        end
                        default:
                        begin
                            length_next     = rx_byte;
                            hdr_count_next  = HDR_MARK;
                            body_count_next = '0;
                            if (!second_ok_reg)
                            begin
                                phase_next = PH_HUNT;
                            end
                            else if (rx_byte < MIN_LEN)
                            begin
                                phase_next       = PH_HUNT;
                                res_valid        = 1'b1;
                                res.last         = 1'b1;
                                res.length_error = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BODY;
                            end
                        end
                    endcase
                end
                PH_BODY:
                begin
                    if (body_count_reg == 8'd0)
                    begin
                        instr_next      = rx_byte;
                        body_count_next = 8'd1;
                    end
                    else
                    begin
                        res_valid         = 1'b1;
                        res.instruction   = instr_reg;
                        res.payload_count = pcount;
                        res.data_byte     = rx_byte;
                        if (body_done)
                        begin
                            res.byte_index  = pcount;
                            res.last        = 1'b1;
                            phase_next      = PH_HUNT;
                            body_count_next = '0;
                        end
                        else
                        begin
                            res.byte_index  = body_count_reg - 8'd1;
                            body_count_next = body_count_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                    // Hunting; the unused phase code falls back here too.
                    phase_next = PH_HUNT;
                    if (rx_byte == MARKER)
                    begin
                        phase_next     = PH_HEADER;
                        hdr_count_next = HDR_MARK;
                        second_ok_next = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            hdr_count_reg  <= HDR_MARK;
            second_ok_reg  <= 1'b0;
            id_reg         <= '0;
            length_reg     <= '0;
            instr_reg      <= '0;
            body_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_count_reg  <= hdr_count_next;
            second_ok_reg  <= second_ok_next;
            id_reg         <= id_next;
            length_reg     <= length_next;
            instr_reg      <= instr_next;
            body_count_reg <= body_count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/sbpd_out_reg.sv]
// Result register that holds one transfer until the downstream side takes it.
// Depends on sbpd_pkg for the result type.
`default_nettype none

module sbpd_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  sbpd_pkg::result_t res,
    input  logic              out_stall,
    output logic              ready,
    output logic              out_valid,
    output sbpd_pkg::result_t out_res
);
    import sbpd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    // The register may be refilled in the same cycle its content leaves.
    assign ready      = !valid_reg || !out_stall;
    assign valid_next = ready ? load : valid_reg;
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

[hdl/servo_bus_packet_deframer.sv]
// Top level of the servo bus packet deframer: input register, parser, result register.
// Depends on sbpd_pkg, sbpd_parser and sbpd_out_reg.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+------------------------------------------
//  input    | in_valid / in_stall            | rx_byte
//  output   | out_valid / out_stall          | packet_id, instruction, payload_count,
//           |                                | data_byte, byte_index, last, length_error
//
// One byte is taken per cycle when neither side stalls. A byte is held in the input
// register while the parser decides on it; its result, if any, is loaded into the
// result register when the byte moves on, and is offered from there until the
// downstream side takes it.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall. Reset is asynchronous and active low and returns the
// parser to hunting for the first marker with both registers empty.
`default_nettype none

module servo_bus_packet_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] packet_id,
    output logic [7:0] instruction,
    output logic [7:0] payload_count,
    output logic [7:0] data_byte,
    output logic [7:0] byte_index,
    output logic       last,
    output logic       length_error
);
    import sbpd_pkg::*;

    logic       in_v_reg;
    logic [7:0] byte_reg;
    logic       out_ready;
    logic       advance;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    // The byte in the input register moves on only when the result register
    // can take whatever it produces.
    assign advance  = in_v_reg && out_ready;
    assign in_stall = in_v_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= rx_byte;
        end
    end

    sbpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .rx_byte   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    sbpd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign packet_id     = out_res.packet_id;
    assign instruction   = out_res.instruction;
    assign payload_count = out_res.payload_count;
    assign data_byte     = out_res.data_byte;
    assign byte_index    = out_res.byte_index;
    assign last          = out_res.last;
    assign length_error  = out_res.length_error;

endmodule

`default_nettype wire

[hdl/sbpd_checker.sv]
// Port-level checks for the servo bus packet deframer, bound to the top level.
// Depends only on the ports of servo_bus_packet_deframer.
`default_nettype none

module sbpd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] instruction,
    input logic [7:0] payload_count,
    input logic [7:0] data_byte,
    input logic [7:0] byte_index,
    input logic       last,
    input logic       length_error
);

    // A stalled result stays offered.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A length error always ends the packet and carries empty fields.
    a_lerr_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && length_error |-> last && instruction == 8'd0
            && payload_count == 8'd0 && data_byte == 8'd0 && byte_index == 8'd0)
        else $error("malformed length error result");

    // A parameter byte lies inside the payload.
    a_param_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> byte_index < payload_count && !length_error)
        else $error("parameter index outside payload");

    // The checksum transfer sits just past the payload.
    a_chk_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !length_error |-> byte_index == payload_count)
        else $error("checksum index mismatch");

endmodule

bind servo_bus_packet_deframer sbpd_checker u_sbpd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .instruction   (instruction),
    .payload_count (payload_count),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .last          (last),
    .length_error  (length_error)
);

`default_nettype wire

[tb/tb_servo_bus_packet_deframer.sv]
// Self-checking testbench for the servo bus packet deframer top level.
// Depends on sbpd_pkg and servo_bus_packet_deframer; stands alone otherwise.
`timescale 1ns / 1ps

module tb_servo_bus_packet_deframer;

    import sbpd_pkg::*;

    localparam int CLK_PERIOD   = 4;
    localparam int SETTLE_TICKS = 10;
    localparam int RUN_LIMIT_NS = 4_000_000;   // overall time limit for the run
    localparam int unsigned HOLD_CYCLES = 300;

    // Parser phases as the predictor tracks them.
    typedef enum logic [1:0] {
        PHASE_HUNT   = 2'd0,
        PHASE_HEADER = 2'd1,
        PHASE_BODY   = 2'd2
    } parse_phase_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] packet_id;
    logic [7:0] instruction;
    logic [7:0] payload_count;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last;
    logic       length_error;

    // Idle rates in percent for the sender and the receiver. A test bumps
    // hold_req to ask for a forced receiver hold-off, which the stall process
    // counts down in hold_left.
    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_ack  = 0;
    int unsigned hold_left = 0;

    int unsigned bytes_sent = 0;
    int unsigned mismatches = 0;

    // Predicted results that have not yet left the block, oldest first.
    result_t pending_results[$];

    // The predictor's copy of the parser state.
    parse_phase_t phase      = PHASE_HUNT;
    logic [1:0]   hdr_taken  = '0;
    logic         marker_ok  = 1'b0;
    logic [7:0]   pkt_id     = '0;
    logic [7:0]   pkt_len    = '0;
    logic [7:0]   pkt_instr  = '0;
    logic [7:0]   body_taken = '0;

    servo_bus_packet_deframer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_id     (packet_id),
        .instruction   (instruction),
        .payload_count (payload_count),
        .data_byte     (data_byte),
        .byte_index    (byte_index),
        .last          (last),
        .length_error  (length_error)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advances the predicted parser by one accepted byte and queues the result
    // that the byte causes, if any. The header is FF FF ID LEN; a body of LEN
    // bytes follows: the instruction (kept, no result), LEN-2 parameter bytes and
    // the checksum. A bad second marker is only found once the length is in, and
    // the dropped bytes are never looked at again for a marker.
    function automatic void deframe_byte(logic [7:0] b);
        result_t    r;
        logic [7:0] param_total;
        r = '0;
        case (phase)
            PHASE_HEADER:
            begin
                if (hdr_taken == 2'd0)
                begin
                    marker_ok = (b == MARKER);
                    hdr_taken = 2'd1;
                end
                else if (hdr_taken == 2'd1)
                begin
                    pkt_id    = b;
                    hdr_taken = 2'd2;
                end
                else
                begin
                    pkt_len    = b;
                    hdr_taken  = 2'd0;
                    body_taken = '0;
                    if (!marker_ok)
                    begin
                        phase = PHASE_HUNT;
                    end
                    else if (pkt_len < MIN_LEN)
                    begin
                        // A length below two ends the packet with an error flag.
                        phase          = PHASE_HUNT;
                        r.packet_id    = pkt_id;
                        r.last         = 1'b1;
                        r.length_error = 1'b1;
                        pending_results.push_back(r);
                    end
                    else
                    begin
                        phase = PHASE_BODY;
                    end
                end
            end
            PHASE_BODY:
            begin
                param_total = pkt_len - MIN_LEN;
                if (body_taken == '0)
                begin
                    pkt_instr  = b;
                    body_taken = 8'd1;
                end
                else
                begin
                    r.packet_id     = pkt_id;
                    r.instruction   = pkt_instr;
                    r.payload_count = param_total;
                    r.data_byte     = b;
                    if ({1'b0, body_taken} + 9'd1 >= {1'b0, pkt_len})
                    begin
                        // The checksum byte carries the index just past the payload.
                        r.byte_index = param_total;
                        r.last       = 1'b1;
                        phase        = PHASE_HUNT;
                        body_taken   = '0;
                    end
                    else
                    begin
                        r.byte_index = body_taken - 8'd1;
                        body_taken   = body_taken + 8'd1;
                    end
                    pending_results.push_back(r);
                end
            end
            default:
            begin
                phase = PHASE_HUNT;
                if (b == MARKER)
                begin
                    phase     = PHASE_HEADER;
                    hdr_taken = 2'd0;
                    marker_ok = 1'b0;
                end
            end
        endcase
    endfunction

    // Offers one byte after a random number of idle cycles and returns once the
    // transfer has happened. Outputs are read right at the edge, before any of
    // the block's registers move, so the stall seen is the one the edge used.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    // The sender goes quiet until every predicted result has left the block.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // One frame of random shape: mostly well-formed packets with short bodies,
    // with some stray bytes, bad second markers, length errors and rare long packets.
    task automatic send_frame();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(99);
        if (kind < 8)
        begin
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        end
        else
        begin
            send_byte(MARKER);
            send_byte(kind < 14 ? 8'($urandom_range(254)) : MARKER);
            send_byte(8'($urandom));
            if (kind < 20)
                len = $urandom_range(1);
            else if ($urandom_range(79) == 0)
                len = $urandom_range(255, 2);
            else
                len = $urandom_range(12, 2);
            send_byte(8'(len));
            if (kind >= 20)
            begin
                repeat (len) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%02h, actual 0x%02h", name, want, got);
            mismatches++;
        end
    endtask

    // Every result transfer is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: data_byte 0x%02h, last %0b", data_byte, last);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("packet_id",     want.packet_id,     packet_id);
                check_field("instruction",   want.instruction,   instruction);
                check_field("payload_count", want.payload_count, payload_count);
                check_field("data_byte",     want.data_byte,     data_byte);
                check_field("byte_index",    want.byte_index,    byte_index);
                check_field("last",          8'(want.last),         8'(last));
                check_field("length_error",  8'(want.length_error), 8'(length_error));
            end
        end
    end

    // The receiver stalls at the current rate, or solidly during a hold-off.
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Stray bytes, a bad second marker whose length byte is a marker value that
    // must not restart the header, and both lengths below two.
    task automatic test_header_cases();
        logic [7:0] seq[$];
        seq = '{8'h00, 8'hFE, 8'hFF, 8'h00, 8'h12, 8'hFF, 8'h00,
                8'hFF, 8'hFF, 8'h00, 8'h00,
                8'hFF, 8'hFF, 8'hFE, 8'h01};
        foreach (seq[i]) send_byte(seq[i]);
        wait_drained();
    endtask

    // A packet with no parameters and a small one with extreme byte values.
    task automatic test_short_packets();
        logic [7:0] seq[$];
        seq = '{8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h80, 8'h7F,
                8'hFF, 8'hFF, 8'h01, 8'h04, 8'h03, 8'h00, 8'hFF, 8'hC3};
        foreach (seq[i]) send_byte(seq[i]);
        wait_drained();
    endtask

    // The longest body the length field allows, so the index reaches its top.
    task automatic test_longest_packet();
        send_byte(MARKER);
        send_byte(MARKER);
        send_byte(8'hFF);
        send_byte(8'hFF);
        for (int i = 0; i < 255; i++) send_byte(8'(255 - i));
        wait_drained();
    endtask

    task automatic test_random_stream(input int unsigned count, input int unsigned sender_idle,
                                      input int unsigned receiver_stall);
        int unsigned target;
        target    = bytes_sent + count;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        while (bytes_sent < target) send_frame();
        wait_drained();
    endtask

    // The receiver holds off long enough for the block to fill and stall its
    // input while the sender keeps offering bytes back to back.
    task automatic test_backpressure();
        int unsigned target;
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = hold_req + 1;
        target    = bytes_sent + 120;
        while (bytes_sent < target) send_frame();
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_cases();
        test_short_packets();
        test_longest_packet();
        test_random_stream(400, 0, 0);
        test_random_stream(400, 73, 0);
        test_random_stream(400, 0, 73);
        test_random_stream(400, 9, 9);
        test_backpressure();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("servo_bus_packet_deframer test passed");
        else
            $display("servo_bus_packet_deframer test failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("servo_bus_packet_deframer test failed");
        $finish;
    end

endmodule
